// ----- src/pvd_pkg.sv -----
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared types and constants for the prefix-length varint decoder.
// ----------------------------------------------------------------------------
package pvd_pkg;

  // Length of an encoded varint in bytes, 1 to 9.
  localparam int unsigned LenW = 4;
  localparam int unsigned ValW = 64;

  localparam logic [LenW-1:0] LenOne  = 4'd1;
  localparam logic [LenW-1:0] LenMax  = 4'd9;

  // Bias added to the payload for each length.
  localparam logic [ValW-1:0] Base2 = 64'h0000_0000_0000_0080;
  localparam logic [ValW-1:0] Base3 = 64'h0000_0000_0000_4080;
  localparam logic [ValW-1:0] Base4 = 64'h0000_0000_0020_4080;
  localparam logic [ValW-1:0] Base5 = 64'h0000_0000_1020_4080;
  localparam logic [ValW-1:0] Base6 = 64'h0000_0008_1020_4080;
  localparam logic [ValW-1:0] Base7 = 64'h0000_0408_1020_4080;
  localparam logic [ValW-1:0] Base8 = 64'h0002_0408_1020_4080;
  localparam logic [ValW-1:0] Base9 = 64'h0102_0408_1020_4080;

  // One classified byte, passed from the front end to the back end.
  typedef struct packed {
    logic            first;  // opens a new varint
    logic            last;   // closes the varint
    logic [LenW-1:0] len;    // length of the varint it belongs to
    logic [7:0]      data;   // payload bits of this byte
  } pvd_entry_t;

  // Bias for a given length; unused codes give zero.
  function automatic logic [ValW-1:0] pvd_base(input logic [LenW-1:0] len);
    logic [ValW-1:0] base;
    base = '0;
    unique case (len)
      4'd2:    base = Base2;
      4'd3:    base = Base3;
      4'd4:    base = Base4;
      4'd5:    base = Base5;
      4'd6:    base = Base6;
      4'd7:    base = Base7;
      4'd8:    base = Base8;
      4'd9:    base = Base9;
      default: base = '0;
    endcase
    return base;
  endfunction

endpackage

// ----- src/pvd_front.sv -----
// ----------------------------------------------------------------------------
// pvd_front
// Accepts input bytes, tracks varint framing and classifies each byte.
// ----------------------------------------------------------------------------
module pvd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         in_byte_i,
  output logic               in_stall_o,
  input  logic               q_full_i,
  output logic               push_o,
  output pvd_pkg::pvd_entry_t entry_o
);
  import pvd_pkg::*;

  logic [LenW-1:0] rem_q, rem_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] ones;
  logic [LenW-1:0] first_len;
  logic [7:0]      top_mask;
  logic            is_first;
  logic            found_zero;

  // Count leading one bits of the byte.
  always_comb begin
    ones       = '0;
    found_zero = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found_zero && in_byte_i[i]) begin
        ones = ones + 4'd1;
      end else begin
        found_zero = 1'b1;
      end
    end
  end

  assign first_len = ones + LenOne;
  assign top_mask  = 8'hFF >> first_len;
  assign is_first  = (rem_q == '0);

  // The byte is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classification of the current byte.
  always_comb begin
    entry_o.first = is_first;
    if (is_first) begin
      entry_o.last = (first_len == LenOne);
      entry_o.len  = first_len;
      entry_o.data = in_byte_i & top_mask;
    end else begin
      entry_o.last = (rem_q == 4'd1);
      entry_o.len  = len_q;
      entry_o.data = in_byte_i;
    end
  end

  // Framing counters.
  always_comb begin
    rem_d = rem_q;
    len_d = len_q;
    if (push_o) begin
      if (is_first) begin
        len_d = first_len;
        rem_d = first_len - LenOne;
      end else begin
        rem_d = rem_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      len_q <= '0;
    end else begin
      rem_q <= rem_d;
      len_q <= len_d;
    end
  end

  // A varint never needs more than eight further bytes.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 4'd8) else $error("pvd_front: remaining count out of range");

  // While a varint is open its length covers the bytes still expected.
  a_len_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) |-> (len_q > rem_q && len_q <= LenMax))
    else $error("pvd_front: length does not cover remaining bytes");

  // The last byte of any varint counts the remaining bytes down to zero.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && entry_o.last) |=> (rem_q == '0))
    else $error("pvd_front: framing not closed after last byte");

endmodule

// ----- src/pvd_fifo.sv -----
// ----------------------------------------------------------------------------
// pvd_fifo
// Small queue of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module pvd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pvd_pkg::pvd_entry_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output pvd_pkg::pvd_entry_t rdata_o
);
  import pvd_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  pvd_entry_t      mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth)) else $error("pvd_fifo: count above depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pvd_fifo: pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("pvd_fifo: push into full queue");

endmodule

// ----- src/pvd_back.sv -----
// ----------------------------------------------------------------------------
// pvd_back
// Gathers payload bytes, adds the length bias and holds the result.
// ----------------------------------------------------------------------------
module pvd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  pvd_pkg::pvd_entry_t           entry_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pvd_pkg::ValW-1:0]      decoded_value_o,
  output logic [pvd_pkg::LenW-1:0]      encoded_length_o
);
  import pvd_pkg::*;

  logic [ValW-1:0] acc_q, acc_d;
  logic [ValW-1:0] acc_next;
  logic [ValW-1:0] val_q, val_d;
  logic [LenW-1:0] len_q, len_d;
  logic            vld_q, vld_d;
  logic            slot_free;

  // The output slot is free when empty or being taken this cycle.
  assign slot_free = !vld_q || !out_stall_i;
  assign pop_o     = !q_empty_i && (!entry_i.last || slot_free);

  // Shift the byte into the payload; a first byte starts fresh.
  assign acc_next = entry_i.first ? {{(ValW-8){1'b0}}, entry_i.data}
                                  : {acc_q[ValW-9:0], entry_i.data};

  always_comb begin
    acc_d = acc_q;
    val_d = val_q;
    len_d = len_q;
    vld_d = vld_q && out_stall_i;
    if (pop_o) begin
      acc_d = acc_next;
      if (entry_i.last) begin
        val_d = pvd_base(entry_i.len) + acc_next;
        len_d = entry_i.len;
        vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      acc_q <= '0;
    end else begin
      vld_q <= vld_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    len_q <= len_d;
  end

  assign out_valid_o      = vld_q;
  assign decoded_value_o  = val_q;
  assign encoded_length_o = len_q;

  // A result is never written over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && entry_i.last) |-> slot_free)
    else $error("pvd_back: result overwritten while stalled");

  // Popping a last byte always shows a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && entry_i.last) |=> out_valid_o)
    else $error("pvd_back: missing result after last byte");

  // Result lengths stay within one to nine bytes.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (encoded_length_o >= LenOne && encoded_length_o <= LenMax))
    else $error("pvd_back: result length out of range");

endmodule

// ----- src/prefix_varint_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// prefix_varint_decoder_unit
// Prefix-length varint decoder: one byte in per transaction, one decoded
// 64-bit value and its length out per complete varint.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+---------------------------
//  in       | input     | in_valid_i / in_stall_o | in_byte_i[7:0]
//  out      | output    | out_valid_o/ out_stall_i| decoded_value_o[63:0],
//           |           |                         | encoded_length_o[3:0]
//
//  One byte is accepted per cycle while the queue has room, set by the
//  combinational classifier and the one-byte-per-cycle accumulator in the back end.
//  A result is registered in the back end when its last byte leaves the queue;
//  a stalled result on the output can delay that.
//  Reset drops any partial varint; the next byte opens a new one.
//  Output stalls fill the queue of QueueDepth entries, then stall the input.
// ----------------------------------------------------------------------------
module prefix_varint_decoder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [7:0]                    in_byte_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pvd_pkg::ValW-1:0]      decoded_value_o,
  output logic [pvd_pkg::LenW-1:0]      encoded_length_o
);
  import pvd_pkg::*;

  pvd_entry_t push_entry;
  pvd_entry_t pop_entry;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;

  // Front end: framing and byte classification.
  pvd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Queue decoupling the two halves.
  pvd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .rdata_o (pop_entry)
  );

  // Back end: payload accumulation, bias add and result register.
  pvd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .entry_i          (pop_entry),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .decoded_value_o  (decoded_value_o),
    .encoded_length_o (encoded_length_o)
  );

endmodule

// ----- tb/tb_prefix_varint_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_prefix_varint_decoder_unit
// Self-checking testbench for the prefix-length varint decoder. A byte stream
// of directed and random varints is driven into the block. A scoreboard
// tracks the decoder state and predicts every decoded value and length. Each
// output transaction is checked against the oldest pending prediction. Both
// channels idle in random bursts, except in the final stretch of the run.
// ----------------------------------------------------------------------------
module tb_prefix_varint_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ValW = pvd_pkg::ValW;
  localparam int unsigned LenW = pvd_pkg::LenW;

  // Random stimulus size and the point where idling stops.
  localparam int RandomBytes = 400;
  localparam int QuietFrom   = 340;
  // Cycles without any transaction before the run is declared hung.
  localparam int StuckLimit  = 1000;
  // Slack after the last result.
  localparam int DrainCycles = 10;
  localparam int MaxPrints   = 20;

  // One decoded varint as seen on the output channel.
  typedef struct packed {
    logic [ValW-1:0] value;
    logic [LenW-1:0] len;
  } decoded_t;

  // Scoreboard: tracks the decoder state and holds the pending results.
  class varint_scoreboard;
    logic [3:0]      bytes_left;
    logic [LenW-1:0] total_len;
    logic [ValW-1:0] payload;
    decoded_t        pending_q[$];
    int              errors;
    int              bytes_seen;
    int              values_seen;
    int              len_hits[10];

    function new();
      bytes_left  = '0;
      total_len   = '0;
      payload     = '0;
      errors      = 0;
      bytes_seen  = 0;
      values_seen = 0;
      foreach (len_hits[i]) len_hits[i] = 0;
    endfunction

    // Prints one mismatch line (up to a cap) and counts it.
    task report(string msg);
      if (errors < MaxPrints) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Bias added to the payload for a given length.
    function logic [ValW-1:0] length_bias(logic [LenW-1:0] len);
      case (len)
        4'd2:    return 64'h0000_0000_0000_0080;
        4'd3:    return 64'h0000_0000_0000_4080;
        4'd4:    return 64'h0000_0000_0020_4080;
        4'd5:    return 64'h0000_0000_1020_4080;
        4'd6:    return 64'h0000_0008_1020_4080;
        4'd7:    return 64'h0000_0408_1020_4080;
        4'd8:    return 64'h0002_0408_1020_4080;
        4'd9:    return 64'h0102_0408_1020_4080;
        default: return '0;
      endcase
    endfunction

    // Advances the decoder state by one accepted byte.
    function void note_byte(logic [7:0] b);
      int       ones;
      decoded_t res;
      bytes_seen++;
      if (bytes_left == 0) begin
        ones = 0;
        while (ones < 8 && b[7-ones]) ones++;
        if (ones == 0) begin
          res.value = {{(ValW-8){1'b0}}, b};
          res.len   = pvd_pkg::LenOne;
          pending_q.push_back(res);
          payload = '0;
        end else begin
          // The low bits after the prefix and its zero open the payload.
          total_len  = LenW'(ones + 1);
          bytes_left = 4'(ones);
          payload    = {{(ValW-8){1'b0}}, b & (8'hFF >> (ones + 1))};
        end
      end else begin
        payload    = {payload[ValW-9:0], b};
        bytes_left = bytes_left - 4'd1;
        if (bytes_left == 0) begin
          res.value = length_bias(total_len) + payload;
          res.len   = total_len;
          pending_q.push_back(res);
          payload   = '0;
          total_len = '0;
        end
      end
    endfunction

    // Compares one output transaction with the oldest pending result.
    task check_result(logic [ValW-1:0] value, logic [LenW-1:0] len);
      decoded_t exp_res;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result value=%h len=%0d", value, len));
      end else begin
        exp_res = pending_q.pop_front();
        values_seen++;
        if (exp_res.len <= pvd_pkg::LenMax) len_hits[exp_res.len]++;
        if (value !== exp_res.value)
          report($sformatf("decoded_value %h, expected %h", value, exp_res.value));
        if (len !== exp_res.len)
          report($sformatf("encoded_length %0d, expected %0d", len, exp_res.len));
      end
    endtask

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic [7:0]       in_byte_i = 8'h00;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ValW-1:0]  decoded_value_o;
  logic [LenW-1:0]  encoded_length_o;

  varint_scoreboard sb;
  bit               quiet = 1'b0;
  int               stuck_cycles = 0;

  prefix_varint_decoder_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_byte_i        (in_byte_i),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .decoded_value_o  (decoded_value_o),
    .encoded_length_o (encoded_length_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Drives one byte, with an optional idle burst first, and waits for it.
  task send_byte(logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b);
    @(negedge clk_i);
  endtask

  // Payload byte that leans toward the all-zero and all-one extremes.
  function logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Sends a well-formed varint of the given length with random content.
  task send_varint(int len, inout int sent);
    logic [7:0] first;
    first = ~(8'hFF >> (len - 1)) | (8'($urandom) & (8'hFF >> len));
    if (len == 9) first = 8'hFF;
    send_byte(first);
    sent++;
    for (int i = 1; i < len; i++) begin
      send_byte(payload_byte());
      sent++;
    end
  endtask

  // Output stall in random bursts, released for good in the quiet stretch.
  initial begin
    int span;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (quiet || $urandom_range(0, 1) == 0) begin
        out_stall_i <= 1'b0;
        span = $urandom_range(1, 20);
      end else begin
        out_stall_i <= 1'b1;
        span = $urandom_range(1, 12);
      end
      repeat (span - 1) @(negedge clk_i);
    end
  end

  // Output monitor: every accepted result goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(decoded_value_o, encoded_length_o);
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $display("watchdog: no transaction for %0d cycles", StuckLimit);
        $display("TB_ERROR");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Main sequence: reset, directed varints, random stream, drain, verdict.
  initial begin
    int sent;
    int lens_covered;
    sb = new();
    sent = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single-byte extremes and the smallest and largest two-byte forms.
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'hBF);
    send_byte(8'hFF);
    // Nine bytes of all ones: the full 64-bit payload wraps with the bias.
    send_byte(8'hFF);
    repeat (8) send_byte(8'hFF);
    // Eight-byte form has no payload bits in its first byte.
    send_byte(8'hFE);
    repeat (7) send_byte(8'h00);

    // Mostly well-formed varints of every length, some stray bytes.
    while (sent < RandomBytes) begin
      if (sent >= QuietFrom) quiet = 1'b1;
      if ($urandom_range(0, 99) < 85) begin
        send_varint($urandom_range(1, 9), sent);
      end else begin
        send_byte(8'($urandom));
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    // Let the final results drain, then allow some slack.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    lens_covered = 0;
    for (int l = 1; l <= 9; l++) if (sb.len_hits[l] != 0) lens_covered++;
    $display("Checked %0d decoded varints from %0d input bytes.",
             sb.values_seen, sb.bytes_seen);
    $display("Varint lengths exercised: %0d of 9; mismatches: %0d.",
             lens_covered, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pvd_pkg.sv
src/pvd_front.sv
src/pvd_fifo.sv
src/pvd_back.sv
src/prefix_varint_decoder_unit.sv
tb/tb_prefix_varint_decoder_unit.sv
